// File: design/usr_pkg.sv
// ----------------------------------------------------------------------------
// usr_pkg
// shared types and constants for the soft serial receiver
// ----------------------------------------------------------------------------
package usr_pkg;

  // action codes of an input word
  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  // sticky error codes
  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_FRAMING   = 2'd1,
    ERR_COLLISION = 2'd2,
    ERR_UNUSED    = 2'd3
  } err_code_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_RECEIVE_ENABLE = 2'd0,
    REG_BIT_PERIOD     = 2'd1,
    REG_START_DELAY    = 2'd2,
    REG_RESERVED       = 2'd3
  } reg_index_t;

  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 8;

  // data bits plus stop bit
  localparam logic [3:0] FrameSamples = 4'd9;

  localparam logic       ResetReceiveEnable = 1'b1;
  localparam logic [7:0] ResetBitPeriod     = 8'd104;
  localparam logic [7:0] ResetStartDelay    = 8'd156;

  // one status word
  typedef struct packed {
    logic       byte_ready;
    logic [7:0] data_byte;
    logic       error_flag;
    logic [1:0] error_kind;
    logic       receiving;
  } status_t;

endpackage

// File: design/usr_if.sv
// ----------------------------------------------------------------------------
// usr_if
// handshake channels of the soft serial receiver
// ----------------------------------------------------------------------------

// input channel: one action and one pin sample per word
interface usr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic       rx_pin;

  modport source (output valid, output action, output rx_pin, input ready);
  modport sink   (input valid, input action, input rx_pin, output ready);
endinterface

// result channel: one status word per input word
interface usr_out_if;
  logic       valid;
  logic       ready;
  logic       byte_ready;
  logic [7:0] data_byte;
  logic       error_flag;
  logic [1:0] error_kind;
  logic       receiving;

  modport source (output valid, output byte_ready, output data_byte, output error_flag,
                  output error_kind, output receiving, input ready);
  modport sink   (input valid, input byte_ready, input data_byte, input error_flag,
                  input error_kind, input receiving, output ready);
endinterface

// configuration write channel
interface usr_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [usr_pkg::CfgIndexWidth-1:0]  index;
  logic [usr_pkg::CfgDataWidth-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/uart_soft_receiver_unit.sv
// ----------------------------------------------------------------------------
// uart_soft_receiver_unit
// 8N1 serial receiver stepped by one action word per tick
// ----------------------------------------------------------------------------
// result path: a status word enters the result register when its input word
//   is taken, or waits in the skid stage while the result side stalls
// throughput: one word per cycle while the skid stage is free; the receiver
//   state updates in the accepting cycle; input stays open while one result waits
// reset (rst, synchronous): receiver state cleared, result buffer empty,
//   registers back to enable 1, bit period 104, start delay 156
module uart_soft_receiver_unit (
  input  logic       clk,
  input  logic       rst,
  usr_in_if.sink     rx_in,
  usr_out_if.source  res_out,
  usr_cfg_if.sink    cfg
);

  // configuration registers
  logic       receive_enable;
  logic [7:0] bit_period;
  logic [7:0] start_delay;

  logic             take;
  logic             can_push;
  usr_pkg::status_t status;
  usr_pkg::status_t head_word;

  // configuration writes are always taken; an unused index is ignored
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      receive_enable <= usr_pkg::ResetReceiveEnable;
      bit_period     <= usr_pkg::ResetBitPeriod;
      start_delay    <= usr_pkg::ResetStartDelay;
    end else if (cfg.valid) begin
      case (usr_pkg::reg_index_t'(cfg.index))
        usr_pkg::REG_RECEIVE_ENABLE: receive_enable <= cfg.data[0];
        usr_pkg::REG_BIT_PERIOD:     bit_period     <= cfg.data;
        usr_pkg::REG_START_DELAY:    start_delay    <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // input is open while the skid stage is free
  assign rx_in.ready = can_push;
  assign take        = rx_in.valid && can_push;

  // state update for the word being taken
  usr_rx_core u_core (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .action         (rx_in.action),
    .rx_pin         (rx_in.rx_pin),
    .receive_enable (receive_enable),
    .bit_period     (bit_period),
    .start_delay    (start_delay),
    .status         (status)
  );

  // result register and skid stage
  usr_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (take),
    .push_word  (status),
    .can_push   (can_push),
    .head_valid (res_out.valid),
    .pop_ready  (res_out.ready),
    .head_word  (head_word)
  );

  assign res_out.byte_ready = head_word.byte_ready;
  assign res_out.data_byte  = head_word.data_byte;
  assign res_out.error_flag = head_word.error_flag;
  assign res_out.error_kind = head_word.error_kind;
  assign res_out.receiving  = head_word.receiving;

endmodule

// File: design/usr_rx_core.sv
// ----------------------------------------------------------------------------
// usr_rx_core
// receiver state and its update for one input word, registered on acceptance
// ----------------------------------------------------------------------------
module usr_rx_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic [1:0]       action,
  input  logic             rx_pin,
  input  logic             receive_enable,
  input  logic [7:0]       bit_period,
  input  logic [7:0]       start_delay,
  output usr_pkg::status_t status
);

  logic [3:0] bits_left, bits_left_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [7:0] tick_count, tick_count_next;
  logic [7:0] held_byte, held_byte_next;
  logic       has_byte, has_byte_next;
  logic       err_sticky, err_sticky_next;
  logic [1:0] err_code, err_code_next;
  logic [3:0] bits_dec;

  assign bits_dec = bits_left - 4'd1;

  always_comb begin
    bits_left_next  = bits_left;
    shift_byte_next = shift_byte;
    tick_count_next = tick_count;
    held_byte_next  = held_byte;
    has_byte_next   = has_byte;
    err_sticky_next = err_sticky;
    err_code_next   = err_code;
    if (take) begin
      case (usr_pkg::action_t'(action))
        usr_pkg::ACT_TICK: begin
          if (!receive_enable) begin
            bits_left_next = 4'd0;
          end else if (!err_sticky) begin
            if (bits_left == 4'd0) begin
              // idle: low pin is a start bit
              if (!rx_pin) begin
                bits_left_next  = usr_pkg::FrameSamples;
                tick_count_next = start_delay;
              end
            end else if (tick_count > 8'd1) begin
              tick_count_next = tick_count - 8'd1;
            end else begin
              tick_count_next = bit_period;
              bits_left_next  = bits_dec;
              if (bits_dec != 4'd0) begin
                shift_byte_next = {rx_pin, shift_byte[7:1]};
              end else if (!rx_pin) begin
                // stop bit low
                err_sticky_next = 1'b1;
                err_code_next   = usr_pkg::ERR_FRAMING;
              end else begin
                if (has_byte) begin
                  err_sticky_next = 1'b1;
                  err_code_next   = usr_pkg::ERR_COLLISION;
                end
                held_byte_next = shift_byte;
                has_byte_next  = 1'b1;
              end
            end
          end
        end
        usr_pkg::ACT_READ: begin
          has_byte_next = 1'b0;
        end
        usr_pkg::ACT_CLEAR: begin
          err_sticky_next = 1'b0;
          err_code_next   = usr_pkg::ERR_NONE;
          has_byte_next   = 1'b0;
          bits_left_next  = 4'd0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_left  <= 4'd0;
      shift_byte <= 8'd0;
      tick_count <= 8'd0;
      held_byte  <= 8'd0;
      has_byte   <= 1'b0;
      err_sticky <= 1'b0;
      err_code   <= usr_pkg::ERR_NONE;
    end else begin
      bits_left  <= bits_left_next;
      shift_byte <= shift_byte_next;
      tick_count <= tick_count_next;
      held_byte  <= held_byte_next;
      has_byte   <= has_byte_next;
      err_sticky <= err_sticky_next;
      err_code   <= err_code_next;
    end
  end

  // status after this word
  assign status.byte_ready = has_byte_next;
  assign status.data_byte  = held_byte_next;
  assign status.error_flag = err_sticky_next;
  assign status.error_kind = err_code_next;
  assign status.receiving  = (bits_left_next != 4'd0);

endmodule

// File: design/usr_out_buf.sv
// ----------------------------------------------------------------------------
// usr_out_buf
// result register with a skid stage
// ----------------------------------------------------------------------------
module usr_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  usr_pkg::status_t push_word,
  output logic             can_push,
  output logic             head_valid,
  input  logic             pop_ready,
  output usr_pkg::status_t head_word
);

  logic             skid_valid;
  usr_pkg::status_t skid_word;

  assign can_push = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!head_valid || pop_ready) begin
      if (skid_valid) begin
        head_word  <= skid_word;
        head_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        head_word  <= push_word;
        head_valid <= push;
      end
    end else if (push) begin
      skid_word  <= push_word;
      skid_valid <= 1'b1;
    end
  end

endmodule

// File: bench/tb_uart_soft_receiver_unit.sv
// ----------------------------------------------------------------------------
// tb_uart_soft_receiver_unit
// self-checking bench for the soft 8N1 receiver: a queue-fed driver offers
// action/pin words with random gaps, a behavioural model of the receiver
// predicts one status word per accepted input word, and a clocked monitor
// checks every result against the oldest prediction while the result side
// stalls at random, including one long hold-off that backs the block up
// ----------------------------------------------------------------------------
module tb_uart_soft_receiver_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // one input word as queued for the driver
  typedef struct packed {
    usr_pkg::action_t act;
    logic             pin;
  } rx_word_t;

  logic clk;
  logic rst;

  usr_in_if  rx_in_ch ();
  usr_out_if res_ch ();
  usr_cfg_if cfg_ch ();

  uart_soft_receiver_unit i_dut (
    .clk     (clk),
    .rst     (rst),
    .rx_in   (rx_in_ch),
    .res_out (res_ch),
    .cfg     (cfg_ch)
  );

  // ---------------------------------------------------------------------------
  // bench state
  // ---------------------------------------------------------------------------
  rx_word_t          pending_words[$];   // words waiting for the driver
  usr_pkg::status_t  status_expected[$]; // predicted status words, oldest first
  int unsigned words_queued;
  int unsigned words_taken;
  int unsigned mismatch_count;
  int unsigned src_gap;            // idle cycles left before the next input word
  int unsigned sink_gap;           // idle cycles left on the result side
  int unsigned stall_left;         // long hold-off on the result side
  bit          stall_done;
  bit          idle_off;           // set for phases that run without gaps

  // model copy of the configuration registers
  logic        cfg_enable;
  logic [7:0]  cfg_period;
  logic [7:0]  cfg_delay;

  // model copy of the receiver state
  logic [3:0]          bits_due;        // samples still due, stop bit included
  logic [7:0]          shift_reg;
  logic [7:0]          ticks_to_sample;
  logic [7:0]          held;
  logic                held_valid;
  logic                err_set;
  usr_pkg::err_code_t  err_kind;

  // ---------------------------------------------------------------------------
  // clock
  // ---------------------------------------------------------------------------
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // behavioural model: advances the receiver by one word, returns the status
  // ---------------------------------------------------------------------------
  function automatic usr_pkg::status_t rx_predict(usr_pkg::action_t act, logic pin);
    usr_pkg::status_t st;
    case (act)
      usr_pkg::ACT_TICK: begin
        if (!cfg_enable) begin
          // disabled tick drops any frame in progress
          bits_due = 4'd0;
        end else if (err_set) begin
          // frozen until a clear
        end else if (bits_due == 4'd0) begin
          // low line while idle is a start bit
          if (!pin) begin
            bits_due        = usr_pkg::FrameSamples;
            ticks_to_sample = cfg_delay;
          end
        end else if (ticks_to_sample > 8'd1) begin
          ticks_to_sample = ticks_to_sample - 8'd1;
        end else begin
          ticks_to_sample = cfg_period;
          bits_due        = bits_due - 4'd1;
          if (bits_due != 4'd0) begin
            // data bits arrive lsb first
            shift_reg = {pin, shift_reg[7:1]};
          end else if (!pin) begin
            err_set  = 1'b1;
            err_kind = usr_pkg::ERR_FRAMING;
          end else begin
            // unread byte gets overwritten, but the error is flagged
            if (held_valid) begin
              err_set  = 1'b1;
              err_kind = usr_pkg::ERR_COLLISION;
            end
            held       = shift_reg;
            held_valid = 1'b1;
          end
        end
      end
      usr_pkg::ACT_READ: held_valid = 1'b0;
      usr_pkg::ACT_CLEAR: begin
        err_set    = 1'b0;
        err_kind   = usr_pkg::ERR_NONE;
        held_valid = 1'b0;
        bits_due   = 4'd0;
      end
      default: begin
        // status only
      end
    endcase
    st.byte_ready = held_valid;
    st.data_byte  = held;
    st.error_flag = err_set;
    st.error_kind = err_kind;
    st.receiving  = (bits_due != 4'd0);
    return st;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  // bit period or start delay: mostly small, zero and one included
  function automatic logic [7:0] pick_delay();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'($urandom_range(0, 1));
    if (r <= 7) return 8'($urandom_range(2, 6));
    if (r == 8) return 8'($urandom_range(7, 16));
    return 8'($urandom_range(17, 30));
  endfunction

  // ---------------------------------------------------------------------------
  // input driver: takes words from the pending queue, predicts on acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : word_driver
    rx_word_t nxt;
    if (rst) begin
      rx_in_ch.valid <= 1'b0;
    end else begin
      if (rx_in_ch.valid && rx_in_ch.ready) begin
        status_expected.push_back(rx_predict(usr_pkg::action_t'(rx_in_ch.action),
                                             rx_in_ch.rx_pin));
        words_taken++;
      end
      // slot is free once the current word has gone or none is offered
      if (!rx_in_ch.valid || rx_in_ch.ready) begin
        if (src_gap != 0) begin
          src_gap--;
          rx_in_ch.valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          nxt = pending_words.pop_front();
          rx_in_ch.valid  <= 1'b1;
          rx_in_ch.action <= nxt.act;
          rx_in_ch.rx_pin <= nxt.pin;
          if (!idle_off && $urandom_range(0, 3) == 0) src_gap = pick_gap();
        end else begin
          rx_in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // long hold-off on the result side, once, while input keeps coming
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      stall_left <= 0;
      stall_done <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!stall_done && words_taken >= 400) begin
      stall_left <= 300;
      stall_done <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: checks each status word against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : status_monitor
    usr_pkg::status_t got;
    usr_pkg::status_t want;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got.byte_ready = res_ch.byte_ready;
        got.data_byte  = res_ch.data_byte;
        got.error_flag = res_ch.error_flag;
        got.error_kind = res_ch.error_kind;
        got.receiving  = res_ch.receiving;
        if (status_expected.size() == 0) begin
          if (mismatch_count < 10)
            $display({"%0t: status word with nothing expected: ",
                      "rdy=%0b data=%02h err=%0b kind=%0d rx=%0b"},
                     $realtime, got.byte_ready, got.data_byte, got.error_flag,
                     got.error_kind, got.receiving);
          mismatch_count++;
        end else begin
          want = status_expected.pop_front();
          if (got.byte_ready !== want.byte_ready || got.data_byte !== want.data_byte ||
              got.error_flag !== want.error_flag || got.error_kind !== want.error_kind ||
              got.receiving !== want.receiving) begin
            if (mismatch_count < 10)
              $display({"%0t: mismatch exp rdy=%0b data=%02h err=%0b kind=%0d rx=%0b, ",
                        "got rdy=%0b data=%02h err=%0b kind=%0d rx=%0b"},
                       $realtime, want.byte_ready, want.data_byte, want.error_flag,
                       want.error_kind, want.receiving, got.byte_ready, got.data_byte,
                       got.error_flag, got.error_kind, got.receiving);
            mismatch_count++;
          end
        end
      end
      // ready with random gaps, held low through the long hold-off
      if (stall_left != 0) begin
        res_ch.ready <= 1'b0;
      end else if (sink_gap != 0) begin
        sink_gap--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
        if (!idle_off && $urandom_range(0, 3) == 0) sink_gap = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_word(usr_pkg::action_t act, logic pin);
    rx_word_t w;
    w.act = act;
    w.pin = pin;
    pending_words.push_back(w);
    words_queued++;
  endtask

  // wait until every word has been taken and every status word checked
  task automatic wait_drained();
    do @(posedge clk);
    while (words_taken != words_queued || status_expected.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // one register write on the configuration channel, only while drained
  task automatic write_reg(usr_pkg::reg_index_t idx, logic [7:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk);
    while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      usr_pkg::REG_RECEIVE_ENABLE: cfg_enable = value[0];
      usr_pkg::REG_BIT_PERIOD:     cfg_period = value;
      usr_pkg::REG_START_DELAY:    cfg_delay  = value;
      default: begin
        // reserved index is ignored
      end
    endcase
  endtask

  // one frame timed to the current settings: start tick, then each bit
  // level held over the ticks up to its sample point
  task automatic queue_frame(logic [7:0] value, logic stop_level, bit noisy);
    logic [8:0]  bits;
    int unsigned span;
    bits = {stop_level, value};
    push_word(usr_pkg::ACT_TICK, 1'b0);
    for (int k = 0; k < 9; k++) begin
      if (k == 0) span = (cfg_delay > 8'd1) ? cfg_delay : 1;
      else        span = (cfg_period > 8'd1) ? cfg_period : 1;
      for (int t = 1; t <= span; t++) begin
        // glitches only away from the sample point
        if (noisy && t != span && $urandom_range(0, 15) == 0)
          push_word(usr_pkg::ACT_TICK, 1'($urandom_range(0, 1)));
        else
          push_word(usr_pkg::ACT_TICK, bits[k]);
        // idle or read words in between do not move the bit timer
        if (noisy && $urandom_range(0, 40) == 0)
          push_word(($urandom_range(0, 1) != 0) ? usr_pkg::ACT_NONE : usr_pkg::ACT_READ,
                    1'($urandom_range(0, 1)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned rand_start;
    int unsigned phase;
    int unsigned n_frames;
    bit          stop_ok;
    bit          skipped;
    bit          maybe_err;

    rst             = 1'b1;
    rx_in_ch.valid  = 1'b0;
    rx_in_ch.action = usr_pkg::ACT_TICK;
    rx_in_ch.rx_pin = 1'b1;
    res_ch.ready    = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = usr_pkg::REG_RECEIVE_ENABLE;
    cfg_ch.data     = 8'd0;
    words_queued    = 0;
    words_taken     = 0;
    mismatch_count  = 0;
    src_gap         = 0;
    sink_gap        = 0;
    idle_off        = 1'b0;

    // model starts from the reset state
    cfg_enable      = usr_pkg::ResetReceiveEnable;
    cfg_period      = usr_pkg::ResetBitPeriod;
    cfg_delay       = usr_pkg::ResetStartDelay;
    bits_due        = 4'd0;
    shift_reg       = 8'd0;
    ticks_to_sample = 8'd0;
    held            = 8'd0;
    held_valid      = 1'b0;
    err_set         = 1'b0;
    err_kind        = usr_pkg::ERR_NONE;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: status-only words at reset settings, then a start bit
    push_word(usr_pkg::ACT_TICK, 1'b1);
    push_word(usr_pkg::ACT_READ, 1'b1);   // read with nothing held
    push_word(usr_pkg::ACT_NONE, 1'b0);   // no-op action
    push_word(usr_pkg::ACT_CLEAR, 1'b1);
    push_word(usr_pkg::ACT_TICK, 1'b0);   // start bit
    push_word(usr_pkg::ACT_TICK, 1'b0);   // low line inside the frame is no new start bit
    push_word(usr_pkg::ACT_READ, 1'b0);   // no timer advance
    push_word(usr_pkg::ACT_TICK, 1'b1);
    wait_drained();

    // directed: disabling ends the frame still in progress
    write_reg(usr_pkg::REG_RECEIVE_ENABLE, 8'd0);
    push_word(usr_pkg::ACT_TICK, 1'b0);
    push_word(usr_pkg::ACT_TICK, 1'b0);
    wait_drained();

    // directed: zero and one delays, framing error, frozen tick, clear
    write_reg(usr_pkg::REG_RECEIVE_ENABLE, 8'd1);
    write_reg(usr_pkg::REG_BIT_PERIOD, 8'd0);
    write_reg(usr_pkg::REG_START_DELAY, 8'd1);
    queue_frame(8'hFF, 1'b0, 1'b0);
    push_word(usr_pkg::ACT_TICK, 1'b0);
    push_word(usr_pkg::ACT_CLEAR, 1'b1);
    queue_frame(8'h00, 1'b1, 1'b0);
    push_word(usr_pkg::ACT_READ, 1'b1);
    wait_drained();

    // random phases: mostly well-formed frames with random content
    rand_start = words_queued;
    phase      = 0;
    maybe_err  = 1'b0;
    while (words_queued - rand_start < 700) begin
      if (phase == 2) begin
        // slowest settings: full start delay up to the first sample, then clear
        idle_off = 1'b0;
        write_reg(usr_pkg::REG_RECEIVE_ENABLE, 8'd1);
        write_reg(usr_pkg::REG_BIT_PERIOD, 8'd255);
        write_reg(usr_pkg::REG_START_DELAY, 8'd255);
        push_word(usr_pkg::ACT_CLEAR, 1'b1);
        push_word(usr_pkg::ACT_TICK, 1'b1);
        push_word(usr_pkg::ACT_TICK, 1'b0);   // start bit
        repeat (260) push_word(usr_pkg::ACT_TICK, 1'b1);
        push_word(usr_pkg::ACT_CLEAR, 1'b1);
        wait_drained();
      end
      idle_off = ($urandom_range(0, 3) == 0);
      write_reg(usr_pkg::REG_RECEIVE_ENABLE, ($urandom_range(0, 7) == 0) ? 8'd0 : 8'd1);
      if (phase == 0 || $urandom_range(0, 1) != 0)
        write_reg(usr_pkg::REG_BIT_PERIOD, pick_delay());
      if (phase == 0 || $urandom_range(0, 1) != 0)
        write_reg(usr_pkg::REG_START_DELAY, pick_delay());
      if (phase == 0 || $urandom_range(0, 7) == 0)
        write_reg(usr_pkg::REG_RESERVED, 8'($urandom_range(0, 255)));
      n_frames = $urandom_range(2, 5);
      for (int f = 0; f < n_frames; f++) begin
        // occasional noise words of any kind
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 6))
            push_word(usr_pkg::action_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        // clear when an error is likely pending, rarely otherwise
        if (maybe_err ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 9) == 0))
          push_word(usr_pkg::ACT_CLEAR, 1'($urandom_range(0, 1)));
        repeat ($urandom_range(1, 4)) push_word(usr_pkg::ACT_TICK, 1'b1);
        stop_ok = ($urandom_range(0, 9) != 0);
        queue_frame(8'($urandom_range(0, 255)), stop_ok, 1'($urandom_range(0, 1)));
        repeat ($urandom_range(0, 3)) push_word(usr_pkg::ACT_TICK, 1'b1);
        // skipping the read sets up a collision on the next frame
        skipped = ($urandom_range(0, 4) == 0);
        if (!skipped) push_word(usr_pkg::ACT_READ, 1'($urandom_range(0, 1)));
        maybe_err = !stop_ok || skipped;
      end
      wait_drained();
      phase++;
    end

    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && status_expected.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // watchdog
  // ---------------------------------------------------------------------------
  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: sim.f
design/usr_pkg.sv
design/usr_if.sv
design/usr_rx_core.sv
design/usr_out_buf.sv
design/uart_soft_receiver_unit.sv
bench/tb_uart_soft_receiver_unit.sv
